[src/rcp_pkg.sv]
// rcp_pkg: command and configuration codes, field widths and counter layout
// for the resource credit pool. No dependencies.
package rcp_pkg;

    localparam int REQ_W      = 16;
    localparam int NUM_CNT    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // counter order: tx pkt ulp req/data/net, tx buf ulp req/data/net,
    // rx pkt ulp/net, rx buf ulp/net
    localparam int CNT_TX_PKT_REQ  = 0;
    localparam int CNT_TX_PKT_DATA = 1;
    localparam int CNT_TX_BUF_REQ  = 3;
    localparam int CNT_TX_BUF_DATA = 4;

    // counters checked on their own amount (all but ulp data); the ulp pairs update via rcp_pair
    localparam logic [NUM_CNT-1:0] PLAIN_MASK = 10'b11_1110_1101;

    typedef enum logic [1:0] {
        CMD_CHECK   = 2'd0,
        CMD_ACQUIRE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_LOAD    = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TX_PKT_INIT = 3'd0,
        CFG_TX_BUF_INIT = 3'd1,
        CFG_RX_PKT_INIT = 3'd2,
        CFG_RX_BUF_INIT = 3'd3,
        CFG_OVERSUB_EN  = 3'd4
    } t_cfg_idx;

endpackage

[src/resource_credit_pool.sv]
// resource_credit_pool: ten credit counters with check, acquire, release and
// load commands. Depends on rcp_pkg and rcp_pair.
//
// Usage:
//   Configuration: write the four packed initial-credit registers and the
//   oversubscription enable through i_cfg_* (always ready), only while idle.
//   A load command then copies the registers into the counters.
//   Request channel: i_valid/o_stall carries a command and ten amounts.
//   Result channel: o_valid/i_stall returns fits, pool_loaded and the ten
//   counters as they stand after the command.
// Timing:
//   From transfer to result: an input register, then the counter update and
//   result register in one pass. One request per cycle sustained while
//   i_stall stays low.
// Reset:
//   Synchronous active low; counters, loaded maxima and config registers
//   clear to zero, both pipeline stages empty.
// Stall:
//   With i_stall high the result holds; the input register fills once and
//   then o_stall rises. Counters change only when an item moves to the
//   result register.
module resource_credit_pool
    import rcp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_command,
    input  logic [REQ_W-1:0]      i_req_tx_pkt_ulp_req,
    input  logic [REQ_W-1:0]      i_req_tx_pkt_ulp_data,
    input  logic [REQ_W-1:0]      i_req_tx_pkt_net_req,
    input  logic [REQ_W-1:0]      i_req_tx_buf_ulp_req,
    input  logic [REQ_W-1:0]      i_req_tx_buf_ulp_data,
    input  logic [REQ_W-1:0]      i_req_tx_buf_net_req,
    input  logic [REQ_W-1:0]      i_req_rx_pkt_ulp_req,
    input  logic [REQ_W-1:0]      i_req_rx_pkt_net_req,
    input  logic [REQ_W-1:0]      i_req_rx_buf_ulp_req,
    input  logic [REQ_W-1:0]      i_req_rx_buf_net_req,
    input  logic                  i_req_oversub,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_fits,
    output logic                  o_pool_loaded,
    output logic [REQ_W-1:0]      o_avail_tx_pkt_ulp_req,
    output logic [REQ_W-1:0]      o_avail_tx_pkt_ulp_data,
    output logic [REQ_W-1:0]      o_avail_tx_pkt_net_req,
    output logic [REQ_W-1:0]      o_avail_tx_buf_ulp_req,
    output logic [REQ_W-1:0]      o_avail_tx_buf_ulp_data,
    output logic [REQ_W-1:0]      o_avail_tx_buf_net_req,
    output logic [REQ_W-1:0]      o_avail_rx_pkt_ulp_req,
    output logic [REQ_W-1:0]      o_avail_rx_pkt_net_req,
    output logic [REQ_W-1:0]      o_avail_rx_buf_ulp_req,
    output logic [REQ_W-1:0]      o_avail_rx_buf_net_req
);

    localparam int XW = ((COUNT_WIDTH > REQ_W) ? COUNT_WIDTH : REQ_W) + 2;
    localparam logic [XW-1:0] CMAX_X = {{(XW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
    localparam logic [XW-1:0] AVAIL_MAX_X = XW'({REQ_W{1'b1}});

    // configuration
    logic [CFG_DATA_W-1:0] r_tx_pkt_init, r_tx_buf_init;
    logic [31:0]           r_rx_pkt_init, r_rx_buf_init;
    logic                  r_oversub_en;

    // input stage
    logic                  r_in_vld;
    t_cmd                  r_cmd;
    logic [REQ_W-1:0]      r_req [NUM_CNT];
    logic                  r_req_ov;
    logic [REQ_W-1:0]      in_req [NUM_CNT];

    // state
    logic [COUNT_WIDTH-1:0] r_cnt [NUM_CNT];
    logic [COUNT_WIDTH-1:0] n_cnt [NUM_CNT];
    logic [COUNT_WIDTH-1:0] r_max_req [2];
    logic [COUNT_WIDTH-1:0] n_max_req [2];

    // result stage
    logic                  r_out_vld;
    logic                  r_fits, n_fits;
    logic                  r_loaded, n_loaded;
    logic [REQ_W-1:0]      r_avail [NUM_CNT];
    logic [REQ_W-1:0]      n_avail [NUM_CNT];

    logic                  adv;
    logic                  ov;
    logic [NUM_CNT-1:0]    pl_fail;
    logic [COUNT_WIDTH-1:0] pl_acq [NUM_CNT];
    logic [COUNT_WIDTH-1:0] pl_rel [NUM_CNT];
    logic [COUNT_WIDTH-1:0] ld_cnt [NUM_CNT];
    logic [REQ_W-1:0]      ld_field [NUM_CNT];

    logic                   pr_fit [2];
    logic [COUNT_WIDTH-1:0] pr_acq_req [2], pr_acq_data [2];
    logic [COUNT_WIDTH-1:0] pr_rel_req [2], pr_rel_data [2];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_pkt_init <= '0;
            r_tx_buf_init <= '0;
            r_rx_pkt_init <= '0;
            r_rx_buf_init <= '0;
            r_oversub_en  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TX_PKT_INIT: r_tx_pkt_init <= i_cfg_data;
                CFG_TX_BUF_INIT: r_tx_buf_init <= i_cfg_data;
                CFG_RX_PKT_INIT: r_rx_pkt_init <= i_cfg_data[31:0];
                CFG_RX_BUF_INIT: r_rx_buf_init <= i_cfg_data[31:0];
                CFG_OVERSUB_EN:  r_oversub_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake
    assign adv     = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !adv;
    assign o_valid = r_out_vld;

    assign in_req[0] = i_req_tx_pkt_ulp_req;
    assign in_req[1] = i_req_tx_pkt_ulp_data;
    assign in_req[2] = i_req_tx_pkt_net_req;
    assign in_req[3] = i_req_tx_buf_ulp_req;
    assign in_req[4] = i_req_tx_buf_ulp_data;
    assign in_req[5] = i_req_tx_buf_net_req;
    assign in_req[6] = i_req_rx_pkt_ulp_req;
    assign in_req[7] = i_req_rx_pkt_net_req;
    assign in_req[8] = i_req_rx_buf_ulp_req;
    assign in_req[9] = i_req_rx_buf_net_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd    <= t_cmd'(i_command);
            r_req    <= in_req;
            r_req_ov <= i_req_oversub;
        end
    end

    assign ov = r_req_ov || r_oversub_en;

    // load fields, clamped to the counter width
    assign ld_field[0] = r_tx_pkt_init[15:0];
    assign ld_field[1] = r_tx_pkt_init[31:16];
    assign ld_field[2] = r_tx_pkt_init[47:32];
    assign ld_field[3] = r_tx_buf_init[15:0];
    assign ld_field[4] = r_tx_buf_init[31:16];
    assign ld_field[5] = r_tx_buf_init[47:32];
    assign ld_field[6] = r_rx_pkt_init[15:0];
    assign ld_field[7] = r_rx_pkt_init[31:16];
    assign ld_field[8] = r_rx_buf_init[15:0];
    assign ld_field[9] = r_rx_buf_init[31:16];

    always_comb begin
        logic [XW-1:0] rx, cx, sx, lx;
        for (int i = 0; i < NUM_CNT; i++) begin
            rx = XW'(r_req[i]);
            cx = XW'(r_cnt[i]);
            sx = rx + cx;
            lx = XW'(ld_field[i]);
            pl_fail[i] = rx > cx;
            pl_acq[i]  = COUNT_WIDTH'((cx >= rx) ? (cx - rx) : '0);
            pl_rel[i]  = COUNT_WIDTH'((sx > CMAX_X) ? CMAX_X : sx);
            ld_cnt[i]  = COUNT_WIDTH'((lx > CMAX_X) ? CMAX_X : lx);
        end
    end

    rcp_pair #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_pair_tx_pkt (
        .i_ov         (ov),
        .i_oversub_en (r_oversub_en),
        .i_cnt_req    (r_cnt[CNT_TX_PKT_REQ]),
        .i_cnt_data   (r_cnt[CNT_TX_PKT_DATA]),
        .i_max_req    (r_max_req[0]),
        .i_req_req    (r_req[CNT_TX_PKT_REQ]),
        .i_req_data   (r_req[CNT_TX_PKT_DATA]),
        .o_fit        (pr_fit[0]),
        .o_acq_req    (pr_acq_req[0]),
        .o_acq_data   (pr_acq_data[0]),
        .o_rel_req    (pr_rel_req[0]),
        .o_rel_data   (pr_rel_data[0])
    );

    rcp_pair #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_pair_tx_buf (
        .i_ov         (ov),
        .i_oversub_en (r_oversub_en),
        .i_cnt_req    (r_cnt[CNT_TX_BUF_REQ]),
        .i_cnt_data   (r_cnt[CNT_TX_BUF_DATA]),
        .i_max_req    (r_max_req[1]),
        .i_req_req    (r_req[CNT_TX_BUF_REQ]),
        .i_req_data   (r_req[CNT_TX_BUF_DATA]),
        .o_fit        (pr_fit[1]),
        .o_acq_req    (pr_acq_req[1]),
        .o_acq_data   (pr_acq_data[1]),
        .o_rel_req    (pr_rel_req[1]),
        .o_rel_data   (pr_rel_data[1])
    );

    always_comb begin
        logic [XW-1:0] vx;
        n_fits    = !(|(pl_fail & PLAIN_MASK)) && pr_fit[0] && pr_fit[1];
        n_cnt     = r_cnt;
        n_max_req = r_max_req;
        unique case (r_cmd)
            CMD_CHECK: ;
            CMD_ACQUIRE: begin
                if (n_fits) begin
                    for (int i = 0; i < NUM_CNT; i++) begin
                        if (PLAIN_MASK[i]) n_cnt[i] = pl_acq[i];
                    end
                    n_cnt[CNT_TX_PKT_REQ]  = pr_acq_req[0];
                    n_cnt[CNT_TX_PKT_DATA] = pr_acq_data[0];
                    n_cnt[CNT_TX_BUF_REQ]  = pr_acq_req[1];
                    n_cnt[CNT_TX_BUF_DATA] = pr_acq_data[1];
                end
            end
            CMD_RELEASE: begin
                for (int i = 0; i < NUM_CNT; i++) begin
                    if (PLAIN_MASK[i]) n_cnt[i] = pl_rel[i];
                end
                n_cnt[CNT_TX_PKT_REQ]  = pr_rel_req[0];
                n_cnt[CNT_TX_PKT_DATA] = pr_rel_data[0];
                n_cnt[CNT_TX_BUF_REQ]  = pr_rel_req[1];
                n_cnt[CNT_TX_BUF_DATA] = pr_rel_data[1];
            end
            CMD_LOAD: begin
                n_cnt        = ld_cnt;
                n_max_req[0] = ld_cnt[CNT_TX_PKT_REQ];
                n_max_req[1] = ld_cnt[CNT_TX_BUF_REQ];
            end
        endcase

        n_loaded = 1'b0;
        for (int i = 0; i < NUM_CNT; i++) begin
            vx         = XW'(n_cnt[i]);
            n_loaded   = n_loaded || (n_cnt[i] != '0);
            n_avail[i] = (vx > AVAIL_MAX_X) ? {REQ_W{1'b1}} : vx[REQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '{default: '0};
            r_max_req <= '{default: '0};
            r_out_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_cnt     <= n_cnt;
                r_max_req <= n_max_req;
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fits   <= n_fits;
            r_loaded <= n_loaded;
            r_avail  <= n_avail;
        end
    end

    assign o_fits                  = r_fits;
    assign o_pool_loaded           = r_loaded;
    assign o_avail_tx_pkt_ulp_req  = r_avail[0];
    assign o_avail_tx_pkt_ulp_data = r_avail[1];
    assign o_avail_tx_pkt_net_req  = r_avail[2];
    assign o_avail_tx_buf_ulp_req  = r_avail[3];
    assign o_avail_tx_buf_ulp_data = r_avail[4];
    assign o_avail_tx_buf_net_req  = r_avail[5];
    assign o_avail_rx_pkt_ulp_req  = r_avail[6];
    assign o_avail_rx_pkt_net_req  = r_avail[7];
    assign o_avail_rx_buf_ulp_req  = r_avail[8];
    assign o_avail_rx_buf_net_req  = r_avail[9];

endmodule

[src/rcp_pair.sv]
// rcp_pair: fit check, acquire and release for one ulp request/data pair
// with optional borrowing. Depends on rcp_pkg.
module rcp_pair
    import rcp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_ov,
    input  logic                   i_oversub_en,
    input  logic [COUNT_WIDTH-1:0] i_cnt_req,
    input  logic [COUNT_WIDTH-1:0] i_cnt_data,
    input  logic [COUNT_WIDTH-1:0] i_max_req,
    input  logic [REQ_W-1:0]       i_req_req,
    input  logic [REQ_W-1:0]       i_req_data,
    output logic                   o_fit,
    output logic [COUNT_WIDTH-1:0] o_acq_req,
    output logic [COUNT_WIDTH-1:0] o_acq_data,
    output logic [COUNT_WIDTH-1:0] o_rel_req,
    output logic [COUNT_WIDTH-1:0] o_rel_data
);

    localparam int XW = ((COUNT_WIDTH > REQ_W) ? COUNT_WIDTH : REQ_W) + 2;
    localparam logic [XW-1:0] CMAX_X = {{(XW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

    logic [XW-1:0] rq, rd, cq, cd, mx;
    logic [XW-1:0] from_data, from_req, acq_base, acq_q;
    logic [XW-1:0] base_sum, rel_base;
    logic [XW-1:0] room, refill, sum_q, rem_d, sum_d, rel_q, rel_d;

    always_comb begin
        rq = XW'(i_req_req);
        rd = XW'(i_req_data);
        cq = XW'(i_cnt_req);
        cd = XW'(i_cnt_data);
        mx = XW'(i_max_req);

        o_fit = i_ov ? ((rq + rd) <= (cq + cd)) : (rd <= cd);

        // requests take their own amount, then data drains first and the
        // remainder comes from requests
        acq_base  = (cq >= rq) ? (cq - rq) : '0;
        from_data = (rd < cd) ? rd : cd;
        from_req  = rd - from_data;
        acq_q     = (acq_base >= from_req) ? (acq_base - from_req) : '0;

        base_sum = cq + rq;
        rel_base = (base_sum > CMAX_X) ? CMAX_X : base_sum;
        room     = (rel_base < mx) ? (mx - rel_base) : '0;
        refill   = (rd < room) ? rd : room;
        sum_q    = rel_base + refill;
        rem_d    = rd - refill;
        sum_d    = cd + rd;
        if (i_oversub_en && (i_cnt_data == '0)) begin
            rel_q = (sum_q > CMAX_X) ? CMAX_X : sum_q;
            rel_d = (rem_d > CMAX_X) ? CMAX_X : rem_d;
        end else begin
            rel_q = rel_base;
            rel_d = (sum_d > CMAX_X) ? CMAX_X : sum_d;
        end

        o_acq_req  = acq_q[COUNT_WIDTH-1:0];
        o_acq_data = COUNT_WIDTH'(cd - from_data);
        o_rel_req  = rel_q[COUNT_WIDTH-1:0];
        o_rel_data = rel_d[COUNT_WIDTH-1:0];
    end

endmodule
